// File: rtl/ncube_pkg.sv
// ----------------------------------------------------------------------------
// ncube_pkg
// shared widths, codes and defaults of the normalisation cube texel unit
// ----------------------------------------------------------------------------
package ncube_pkg;

	// field widths
	localparam int FACE_W  = 3;
	localparam int COORD_W = 10;
	localparam int SIZE_W  = 11;
	localparam int BYTE_W  = 8;
	localparam int M_W     = 7;
	localparam int MSQ_W   = 14;

	// defaults
	localparam int                MAX_SIZE_DEF  = 1024;
	localparam logic [SIZE_W-1:0] CUBE_SIZE_RST = 11'd32;
	localparam logic [BYTE_W-1:0] ENC_ZERO      = 8'd128;

	// face codes
	localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

endpackage

// File: rtl/ncube_req_if.sv
// ----------------------------------------------------------------------------
// ncube_req_if
// request channel: cube face and texel position
// ----------------------------------------------------------------------------
interface ncube_req_if import ncube_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FACE_W-1:0]  face;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;

	modport source (output valid, face, col, row, input ready);
	modport sink   (input valid, face, col, row, output ready);
endinterface

// File: rtl/ncube_rsp_if.sv
// ----------------------------------------------------------------------------
// ncube_rsp_if
// response channel: encoded rgb texel
// ----------------------------------------------------------------------------
interface ncube_rsp_if import ncube_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] red_out;
	logic [BYTE_W-1:0] green_out;
	logic [BYTE_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: rtl/ncube_front.sv
// ----------------------------------------------------------------------------
// ncube_front
// direction forming, squaring and length/target sums (stages s1 to s3)
// ----------------------------------------------------------------------------
module ncube_front import ncube_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	parameter int NW       = 11,
	parameter int LW       = 2 * NW + 2,
	parameter int KW       = 2 * NW + 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [FACE_W-1:0]       face,
	input  logic [COORD_W-1:0]      col,
	input  logic [COORD_W-1:0]      row,
	input  logic [SIZE_W-1:0]       cube_size,
	output logic                    v_s3,
	output logic [LW-1:0]           l_s3,
	output logic [2:0][KW-1:0]      k_s3,
	output logic [2:0]              sign_s3,
	output logic                    bad_s3
);
	localparam int SW = NW + 2;
	localparam int CW = ((NW > COORD_W) ? NW : COORD_W) + 1;
	localparam int GW = ((SIZE_W > NW) ? SIZE_W : NW) + 1;
	localparam int QW = 2 * NW;

	logic [NW-1:0]           n_c;
	logic [NW-1:0]           nm1_c;
	logic [NW-1:0]           col_c;
	logic [NW-1:0]           row_c;
	logic signed [SW-1:0]    s_c;
	logic signed [SW-1:0]    t_c;
	logic signed [SW-1:0]    nn_c;
	logic signed [2:0][SW-1:0] comp_c;
	logic                    bad_c;

	logic                    v_s1;
	logic [2:0][NW-1:0]      abs_s1;
	logic [2:0]              sign_s1;
	logic                    bad_s1;

	logic                    v_s2;
	logic [2:0][QW-1:0]      sq_s2;
	logic [2:0]              sign_s2;
	logic                    bad_s2;

	// effective size and clamped coordinates
	always_comb begin
		if (cube_size == '0) begin
			n_c = NW'(1);
		end else if (GW'(cube_size) > GW'(MAX_SIZE)) begin
			n_c = NW'(MAX_SIZE);
		end else begin
			n_c = NW'(cube_size);
		end
		nm1_c = n_c - NW'(1);
		col_c = (CW'(col) > CW'(nm1_c)) ? nm1_c : NW'(col);
		row_c = (CW'(row) > CW'(nm1_c)) ? nm1_c : NW'(row);
		nn_c  = $signed({2'b00, n_c});
		s_c   = $signed({1'b0, col_c, 1'b1}) - nn_c;
		t_c   = $signed({1'b0, row_c, 1'b1}) - nn_c;
	end

	// direction per face
	always_comb begin
		bad_c = 1'b0;
		case (face)
			FACE_PX: begin
				comp_c[0] = nn_c;  comp_c[1] = -t_c;  comp_c[2] = -s_c;
			end
			FACE_NX: begin
				comp_c[0] = -nn_c; comp_c[1] = -t_c;  comp_c[2] = s_c;
			end
			FACE_PY: begin
				comp_c[0] = s_c;   comp_c[1] = nn_c;  comp_c[2] = t_c;
			end
			FACE_NY: begin
				comp_c[0] = s_c;   comp_c[1] = -nn_c; comp_c[2] = -t_c;
			end
			FACE_PZ: begin
				comp_c[0] = s_c;   comp_c[1] = -t_c;  comp_c[2] = nn_c;
			end
			FACE_NZ: begin
				comp_c[0] = -s_c;  comp_c[1] = -t_c;  comp_c[2] = -nn_c;
			end
			default: begin
				comp_c = '0;
				bad_c  = 1'b1;
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: magnitude and sign
			for (int i = 0; i < 3; i++) begin
				sign_s1[i] <= comp_c[i][SW-1];
				abs_s1[i]  <= comp_c[i][SW-1] ? NW'(-comp_c[i]) : NW'(comp_c[i]);
			end
			bad_s1 <= bad_c;
			// s2: squares
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= QW'(abs_s1[i]) * QW'(abs_s1[i]);
			end
			sign_s2 <= sign_s1;
			bad_s2  <= bad_s1;
			// s3: squared length and 127^2 scaled targets
			l_s3 <= LW'(sq_s2[0]) + LW'(sq_s2[1]) + LW'(sq_s2[2]);
			for (int i = 0; i < 3; i++) begin
				k_s3[i] <= (KW'(sq_s2[i]) << 14) - (KW'(sq_s2[i]) << 8) + KW'(sq_s2[i]);
			end
			sign_s3 <= sign_s2;
			bad_s3  <= bad_s2;
		end
	end

endmodule

// File: rtl/ncube_search_step.sv
// ----------------------------------------------------------------------------
// ncube_search_step
// one bit of the per-component quotient search: largest m with m^2*L <= k
// ----------------------------------------------------------------------------
module ncube_search_step import ncube_pkg::*; #(
	parameter int NW  = 11,
	parameter int LW  = 2 * NW + 2,
	parameter int KW  = 2 * NW + 14,
	parameter int BIT = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   v_in,
	input  logic [LW-1:0]          l_in,
	input  logic [2:0][KW-1:0]     k_in,
	input  logic [2:0][M_W-1:0]    m_in,
	input  logic [2:0][MSQ_W-1:0]  msq_in,
	input  logic [2:0]             eq_in,
	input  logic [2:0]             sign_in,
	input  logic                   bad_in,
	output logic                   v_q,
	output logic [LW-1:0]          l_q,
	output logic [2:0][KW-1:0]     k_q,
	output logic [2:0][M_W-1:0]    m_q,
	output logic [2:0][MSQ_W-1:0]  msq_q,
	output logic [2:0]             eq_q,
	output logic [2:0]             sign_q,
	output logic                   bad_q
);
	localparam int PW = MSQ_W + LW;
	localparam logic [M_W-1:0] LO_MASK = M_W'((1 << BIT) - 1);
	localparam logic [M_W-1:0] HI_MASK = M_W'(~((1 << (BIT + 1)) - 1));

	logic [2:0][MSQ_W-1:0] cand_sq;
	logic [2:0][PW-1:0]    prod;
	logic [2:0]            take;

	// trial square built incrementally, then one multiply and compare
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cand_sq[i] = msq_in[i] + (MSQ_W'(m_in[i]) << (BIT + 1))
				+ MSQ_W'(1 << (2 * BIT));
			prod[i]    = PW'(cand_sq[i]) * PW'(l_in);
			take[i]    = prod[i] <= PW'(k_in[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (take[i]) begin
					m_q[i]   <= m_in[i] | M_W'(1 << BIT);
					msq_q[i] <= cand_sq[i];
					eq_q[i]  <= prod[i] == PW'(k_in[i]);
				end else begin
					m_q[i]   <= m_in[i];
					msq_q[i] <= msq_in[i];
					eq_q[i]  <= eq_in[i];
				end
			end
			l_q    <= l_in;
			k_q    <= k_in;
			sign_q <= sign_in;
			bad_q  <= bad_in;
		end
	end

	// running square matches the running quotient
	a_msq_track: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> (msq_q[0] == MSQ_W'(m_q[0]) * MSQ_W'(m_q[0])))
		else $error("running square out of step with quotient");

	// bits below this step still untouched
	a_low_clear: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> ((m_q[1] & LO_MASK) == '0))
		else $error("quotient bits below the current step are set");

	// bits decided earlier are kept
	a_high_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_in) |=> ((m_q[2] & HI_MASK) == ($past(m_in[2]) & HI_MASK)))
		else $error("earlier quotient bits changed");

endmodule

// File: rtl/normalization_cube_texel_unit.sv
// pipeline: 3 front stages, 7 quotient search stages and 1 output register; the
// first stage loads on the accepting edge
// throughput: one texel per cycle; the whole pipe holds while the output
// register is full and not taken
// reset: arst_n clears all valid bits and sets cube_size to 32
// ----------------------------------------------------------------------------
// normalization_cube_texel_unit
// normalisation cube map texel generator, exact integer encoding
// ----------------------------------------------------------------------------
module normalization_cube_texel_unit import ncube_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	ncube_req_if.sink         texel_req,
	ncube_rsp_if.source       texel_rsp
);
	localparam int NW    = $clog2(MAX_SIZE + 1);
	localparam int LW    = 2 * NW + 2;
	localparam int KW    = 2 * NW + 14;
	localparam int STEPS = M_W;

	logic [SIZE_W-1:0] cube_size_q;
	logic              en;

	logic                   v_c    [0:STEPS];
	logic [LW-1:0]          l_c    [0:STEPS];
	logic [2:0][KW-1:0]     k_c    [0:STEPS];
	logic [2:0][M_W-1:0]    m_c    [0:STEPS];
	logic [2:0][MSQ_W-1:0]  msq_c  [0:STEPS];
	logic [2:0]             eq_c   [0:STEPS];
	logic [2:0]             sign_c [0:STEPS];
	logic                   bad_c  [0:STEPS];

	logic                   out_v_q;
	logic [2:0][BYTE_W-1:0] byte_q;
	logic [2:0][BYTE_W-1:0] byte_c;

	// whole pipe advances unless a finished response is held
	assign en              = !out_v_q || texel_rsp.ready;
	assign texel_req.ready = en;

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cube_size_q <= CUBE_SIZE_RST;
		end else if (cfg_we) begin
			cube_size_q <= cfg_wdata;
		end
	end

	ncube_front #(
		.MAX_SIZE (MAX_SIZE),
		.NW       (NW),
		.LW       (LW),
		.KW       (KW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (texel_req.valid),
		.face      (texel_req.face),
		.col       (texel_req.col),
		.row       (texel_req.row),
		.cube_size (cube_size_q),
		.v_s3      (v_c[0]),
		.l_s3      (l_c[0]),
		.k_s3      (k_c[0]),
		.sign_s3   (sign_c[0]),
		.bad_s3    (bad_c[0])
	);

	assign m_c[0]   = '0;
	assign msq_c[0] = '0;
	assign eq_c[0]  = '0;

	// quotient search, most significant bit first
	for (genvar g = 0; g < STEPS; g++) begin : g_step
		ncube_search_step #(
			.NW  (NW),
			.LW  (LW),
			.KW  (KW),
			.BIT (STEPS - 1 - g)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (v_c[g]),
			.l_in    (l_c[g]),
			.k_in    (k_c[g]),
			.m_in    (m_c[g]),
			.msq_in  (msq_c[g]),
			.eq_in   (eq_c[g]),
			.sign_in (sign_c[g]),
			.bad_in  (bad_c[g]),
			.v_q     (v_c[g+1]),
			.l_q     (l_c[g+1]),
			.k_q     (k_c[g+1]),
			.m_q     (m_c[g+1]),
			.msq_q   (msq_c[g+1]),
			.eq_q    (eq_c[g+1]),
			.sign_q  (sign_c[g+1]),
			.bad_q   (bad_c[g+1])
		);
	end

	// byte encoding: floor above zero, ceiling below
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (bad_c[STEPS]) begin
				byte_c[i] = ENC_ZERO;
			end else if (sign_c[STEPS][i]) begin
				byte_c[i] = ENC_ZERO - BYTE_W'(m_c[STEPS][i])
					- BYTE_W'(!eq_c[STEPS][i]);
			end else begin
				byte_c[i] = ENC_ZERO + BYTE_W'(m_c[STEPS][i]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_c[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_q <= byte_c;
		end
	end

	assign texel_rsp.valid     = out_v_q;
	assign texel_rsp.red_out   = byte_q[0];
	assign texel_rsp.green_out = byte_q[1];
	assign texel_rsp.blue_out  = byte_q[2];

endmodule

// File: dv/normalization_cube_texel_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalization_cube_texel_unit_test
// drives face and texel requests through the cube texel unit under several
// cube sizes and idling patterns, and checks every rgb response against an
// exact integer prediction kept in this bench
// ----------------------------------------------------------------------------
module normalization_cube_texel_unit_test;
	import ncube_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} texel_t;

	localparam int LIMIT_CYCLES = 400000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	ncube_req_if texel_req ();
	ncube_rsp_if texel_rsp ();

	normalization_cube_texel_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.texel_req (texel_req),
		.texel_rsp (texel_rsp)
	);

	// predictor state
	logic [SIZE_W-1:0] size_reg;
	texel_t            texel_queue[$];
	int                mismatches;
	int                cycles;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                hold_cycles;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// exact encoding of one component
	function automatic logic [BYTE_W-1:0] encode_byte(longint c, longint len2);
		longint a;
		longint k;
		longint m;
		a = (c < 0) ? -c : c;
		k = 16129 * a * a;
		m = 0;
		while (m < 127 && (m + 1) * (m + 1) * len2 <= k)
			m++;
		if (c >= 0)
			return 8'(128 + m);
		if (m * m * len2 != k)
			m++;
		return 8'(128 - m);
	endfunction

	// expected texel for a request under the current cube size
	function automatic texel_t predict_texel(logic [FACE_W-1:0] face,
			logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
		longint n;
		longint cc;
		longint rr;
		longint s;
		longint t;
		longint x;
		longint y;
		longint z;
		longint len2;
		texel_t res;
		n = size_reg;
		if (n < 1)
			n = 1;
		if (n > MAX_SIZE_DEF)
			n = MAX_SIZE_DEF;
		cc = (col > n - 1) ? n - 1 : col;
		rr = (row > n - 1) ? n - 1 : row;
		s = 2 * cc + 1 - n;
		t = 2 * rr + 1 - n;
		case (face)
			FACE_PX: begin x = n;  y = -t; z = -s; end
			FACE_NX: begin x = -n; y = -t; z = s;  end
			FACE_PY: begin x = s;  y = n;  z = t;  end
			FACE_NY: begin x = s;  y = -n; z = -t; end
			FACE_PZ: begin x = s;  y = -t; z = n;  end
			FACE_NZ: begin x = -s; y = -t; z = -n; end
			default: begin
				res = '{ENC_ZERO, ENC_ZERO, ENC_ZERO};
				return res;
			end
		endcase
		len2 = x * x + y * y + z * z;
		res.red   = encode_byte(x, len2);
		res.green = encode_byte(y, len2);
		res.blue  = encode_byte(z, len2);
		return res;
	endfunction

	// send one request, with optional idle cycles ahead of it
	task automatic send_texel(logic [FACE_W-1:0] face, logic [COORD_W-1:0] col,
			logic [COORD_W-1:0] row);
		if ($urandom_range(99) < send_idle_pct) begin
			texel_req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		texel_req.valid <= 1'b1;
		texel_req.face  <= face;
		texel_req.col   <= col;
		texel_req.row   <= row;
		@(posedge clk);
		while (!texel_req.ready)
			@(posedge clk);
		texel_queue.push_back(predict_texel(face, col, row));
	endtask

	task automatic drain_texels();
		texel_req.valid <= 1'b0;
		while (texel_queue.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] value);
		drain_texels();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = value;
	endtask

	task automatic send_random(int count);
		int i;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] r;
		for (i = 0; i < count; i++) begin
			c = ($urandom_range(3) == 0) ? COORD_W'($urandom) :
				COORD_W'($urandom_range(size_reg + 2));
			r = ($urandom_range(3) == 0) ? COORD_W'($urandom) :
				COORD_W'($urandom_range(size_reg + 2));
			send_texel(($urandom_range(9) == 0) ? FACE_W'($urandom_range(7, 6)) :
				FACE_W'($urandom_range(5)), c, r);
		end
	endtask

	// zero corner on every face, further coordinate extremes, unknown faces, size limits
	task automatic test_directed();
		int f;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (f = 0; f < 8; f++)
			send_texel(FACE_W'(f), '0, '0);
		send_texel(FACE_PX, '1, '1);
		send_texel(FACE_NZ, 10'd31, 10'd0);
		send_texel(FACE_PY, 10'd0, 10'd31);
		send_texel(FACE_NY, 10'd15, 10'd16);
		write_size(11'd0);
		send_texel(FACE_PX, 10'd0, 10'd0);
		send_texel(FACE_NX, '1, '1);
		write_size(11'd1);
		send_texel(FACE_PZ, 10'd5, 10'd0);
		write_size(11'd2047);
		send_texel(FACE_NX, '1, '1);
		send_texel(FACE_PY, 10'd512, 10'd0);
		write_size(11'd1024);
		send_texel(FACE_PZ, '0, '1);
		send_texel(FACE_NZ, 10'h2aa, 10'h155);
	endtask

	// random requests under several sizes and idling mixes
	task automatic test_random();
		int pct[4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{32, 32}};
		int p;
		for (p = 0; p < 4; p++) begin
			send_idle_pct  = pct[p][0];
			recv_stall_pct = pct[p][1];
			write_size(p == 0 ? 11'd1 : p == 1 ? 11'd7 : p == 2 ? 11'd32 : 11'd1024);
			send_random(90);
			write_size(11'($urandom_range(2047)));
			send_random(90);
		end
	endtask

	// long receiver hold-off while requests keep coming, then a full pause
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_size(11'd3);
		hold_cycles = 60;
		send_random(30);
		drain_texels();
		send_random(10);
	endtask

	// response side: stalls and checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_rsp.ready <= 1'b0;
		end else begin
			if (texel_rsp.valid && texel_rsp.ready) begin
				if (texel_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected texel %h %h %h", texel_rsp.red_out,
							texel_rsp.green_out, texel_rsp.blue_out);
				end else begin
					texel_t exp_t;
					exp_t = texel_queue.pop_front();
					if (exp_t.red !== texel_rsp.red_out ||
							exp_t.green !== texel_rsp.green_out ||
							exp_t.blue !== texel_rsp.blue_out) begin
						mismatches++;
						if (mismatches <= 10)
							$display("texel mismatch: expected %h %h %h, got %h %h %h",
								exp_t.red, exp_t.green, exp_t.blue, texel_rsp.red_out,
								texel_rsp.green_out, texel_rsp.blue_out);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				texel_rsp.ready <= 1'b0;
			end else begin
				texel_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		size_reg = CUBE_SIZE_RST;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		texel_req.valid = 1'b0;
		texel_req.face = '0;
		texel_req.col = '0;
		texel_req.row = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		drain_texels();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
